FILE: rtl/sequence_buffer_front_back_middle_macros.svh
// Assertion macros used by the sequence buffer control block.
`ifndef SEQUENCE_BUFFER_FRONT_BACK_MIDDLE_MACROS_SVH
`define SEQUENCE_BUFFER_FRONT_BACK_MIDDLE_MACROS_SVH

`ifndef SYNTHESIS
`define SBFBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbfbm: same-cycle check failed");
`define SBFBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbfbm: next-cycle check failed");
`else
`define SBFBM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBFBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/sbfbm_pkg.sv
// Shared types and constants of the sequence buffer.
package sbfbm_pkg;

	localparam int DATA_W  = 32;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_INS_MID    = 3'd4;
	localparam logic [OP_W-1:0] OP_REM_MID    = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] removed_value;
		logic                     removed_valid;
		logic [STAT_W-1:0]        status;
		logic [COUNT_W-1:0]       count;
	} res_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} ctl_t;

	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_LOAD,
		ACT_FROM_LEFT,
		ACT_FROM_RIGHT
	} cell_act_t;

endpackage

FILE: rtl/sbfbm_cell.sv
// One storage cell of the buffer chain: holds, loads, or takes a neighbor's entry.
module sbfbm_cell (
	input  logic                          clk,
	input  sbfbm_pkg::cell_act_t          act,
	input  logic [sbfbm_pkg::DATA_W-1:0]  load_val,
	input  logic [sbfbm_pkg::DATA_W-1:0]  left_val,
	input  logic [sbfbm_pkg::DATA_W-1:0]  right_val,
	output logic [sbfbm_pkg::DATA_W-1:0]  entry_q
);
	import sbfbm_pkg::*;

	always_ff @(posedge clk) begin
		case (act)
			ACT_LOAD:       entry_q <= load_val;
			ACT_FROM_LEFT:  entry_q <= left_val;
			ACT_FROM_RIGHT: entry_q <= right_val;
			default:        entry_q <= entry_q;
		endcase
	end

endmodule

FILE: rtl/sbfbm_ctrl.sv
// Occupancy tracking, operation decode and position selection for the buffer.
`include "sequence_buffer_front_back_middle_macros.svh"

module sbfbm_ctrl #(
	parameter int CAPACITY = 16,
	localparam int PW = $clog2(CAPACITY),
	localparam int NW = $clog2(CAPACITY + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic [sbfbm_pkg::OP_W-1:0]     op,
	output sbfbm_pkg::ctl_t                ctl,
	output logic [PW-1:0]                  pos,
	output logic [sbfbm_pkg::STAT_W-1:0]   status,
	output logic [sbfbm_pkg::COUNT_W-1:0]  count
);
	import sbfbm_pkg::*;

	localparam logic [NW-1:0] CAP_N = NW'(CAPACITY);

	logic [NW-1:0] occ_q;
	logic [NW-1:0] occ_next;
	logic [NW-1:0] pos_n;
	logic [NW-1:0] half_n;
	logic          full;
	logic          empty;
	ctl_t          ctl_raw;

	assign full   = (occ_q == CAP_N);
	assign empty  = (occ_q == '0);
	assign half_n = (occ_q - NW'(1)) >> 1;

	always_comb begin
		ctl_raw = '0;
		pos_n   = '0;
		status  = ST_OK;
		if (op inside {OP_PUSH_FRONT, OP_PUSH_BACK, OP_INS_MID}) begin
			if (full) begin
				status = ST_FULL;
			end else begin
				ctl_raw.ins = 1'b1;
			end
		end else if (op inside {OP_POP_FRONT, OP_POP_BACK, OP_REM_MID}) begin
			if (empty) begin
				status = ST_EMPTY;
			end else begin
				ctl_raw.rem = 1'b1;
			end
		end
		case (op)
			OP_PUSH_FRONT: pos_n = '0;
			OP_POP_FRONT:  pos_n = '0;
			OP_PUSH_BACK:  pos_n = occ_q;
			OP_POP_BACK:   pos_n = occ_q - NW'(1);
			OP_INS_MID: begin
				pos_n = empty ? '0 : half_n + NW'(1);
			end
			OP_REM_MID: begin
				if (occ_q == NW'(1)) begin
					pos_n = '0;
				end else if (half_n == '0) begin
					pos_n = NW'(1);
				end else begin
					pos_n = half_n;
				end
			end
			default: pos_n = '0;
		endcase
	end

	assign ctl.ins  = ctl_raw.ins & fire;
	assign ctl.rem  = ctl_raw.rem & fire;
	assign pos      = PW'(pos_n);
	assign occ_next = occ_q + NW'(ctl_raw.ins) - NW'(ctl_raw.rem);
	assign count    = COUNT_W'(occ_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (fire) begin
			occ_q <= occ_next;
		end
	end

	`SBFBM_ASSERT_IMPL(a_occ_bound, clk, arst_n, 1'b1, occ_q <= CAP_N)
	`SBFBM_ASSERT_NEXT(a_ins_grows, clk, arst_n, ctl.ins, occ_q == $past(occ_q) + NW'(1))
	`SBFBM_ASSERT_NEXT(a_rem_shrinks, clk, arst_n, ctl.rem, occ_q == $past(occ_q) - NW'(1))
	`SBFBM_ASSERT_IMPL(a_one_action, clk, arst_n, 1'b1, !(ctl.ins && ctl.rem))

endmodule

FILE: rtl/sequence_buffer_front_back_middle.sv
// Top level of the sequence buffer: cell chain, control and result register.
// The result of a command is registered in the cycle after its command transfer.
// Throughput: one operation per cycle while cmd_stall is low; every cell shifts, loads or holds in parallel.
// The removed entry is picked from the cell chain by the decoded position.
// Reset clears the occupancy and the result valid flag; cell contents are not cleared.
module sequence_buffer_front_back_middle #(
	parameter int CAPACITY = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  sbfbm_pkg::cmd_t cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output sbfbm_pkg::res_t res
);
	import sbfbm_pkg::*;

	localparam int PW = $clog2(CAPACITY);

	logic                    fire;
	ctl_t                    ctl;
	logic [PW-1:0]           pos;
	logic [STAT_W-1:0]       status;
	logic [COUNT_W-1:0]      count;
	logic [DATA_W-1:0]       entry_w [CAPACITY];
	logic [DATA_W-1:0]       left_w  [CAPACITY];
	logic [DATA_W-1:0]       right_w [CAPACITY];
	cell_act_t               act_w   [CAPACITY];
	logic                    res_valid_q;
	res_t                    res_q;

	assign cmd_stall = res_valid_q & res_stall;
	assign fire      = cmd_valid & ~cmd_stall;

	sbfbm_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (cmd.op),
		.ctl    (ctl),
		.pos    (pos),
		.status (status),
		.count  (count)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_w[i] = '0;
		end else begin : g_inner_l
			assign left_w[i] = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w[i] = '0;
		end else begin : g_inner_r
			assign right_w[i] = entry_w[i+1];
		end

		always_comb begin
			if (ctl.ins && (pos == PW'(i))) begin
				act_w[i] = ACT_LOAD;
			end else if (ctl.ins && (pos < PW'(i))) begin
				act_w[i] = ACT_FROM_LEFT;
			end else if (ctl.rem && (pos <= PW'(i))) begin
				act_w[i] = ACT_FROM_RIGHT;
			end else begin
				act_w[i] = ACT_HOLD;
			end
		end

		sbfbm_cell u_cell (
			.clk       (clk),
			.act       (act_w[i]),
			.load_val  (cmd.value),
			.left_val  (left_w[i]),
			.right_val (right_w[i]),
			.entry_q   (entry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.removed_value <= ctl.rem ? entry_w[pos] : '0;
			res_q.removed_valid <= ctl.rem;
			res_q.status        <= status;
			res_q.count         <= count;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sequence buffer: a directed table, then random operations.
module testbench;
	import sbfbm_pkg::*;

	localparam int CAPACITY = 16;
	localparam int ITEMS = 550;
	localparam int CALM_ITEMS = 60;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 1000;
	localparam int REPORT_LIMIT = 10;
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	logic signed [DATA_W-1:0] held_values[$];
	res_t awaited_results[$];
	row_t directed_rows[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit calm = 0;
	bit squeeze_req = 0;
	bit squeeze_done = 0;

	sequence_buffer_front_back_middle #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_t outcome(logic signed [DATA_W-1:0] v, logic vld,
			logic [STAT_W-1:0] st, int cnt);
		res_t r;
		r.removed_value = v;
		r.removed_valid = vld;
		r.status = st;
		r.count = COUNT_W'(cnt);
		return r;
	endfunction

	function automatic res_t apply_op(cmd_t c);
		res_t r;
		int n;
		int pos;
		r = '0;
		r.status = ST_OK;
		n = held_values.size();
		pos = 0;
		case (c.op)
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_INS_MID: begin
				if (n >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					if (c.op == OP_PUSH_BACK) pos = n;
					else if (c.op == OP_INS_MID && n > 0) pos = (n - 1) / 2 + 1;
					if (pos == n) held_values.push_back(c.value);
					else held_values.insert(pos, c.value);
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_REM_MID: begin
				if (n == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (c.op == OP_POP_BACK) pos = n - 1;
					else if (c.op == OP_REM_MID && n > 1) pos = ((n - 1) / 2 < 1) ? 1 : (n - 1) / 2;
					r.removed_value = held_values[pos];
					r.removed_valid = 1'b1;
					held_values.delete(pos);
				end
			end
			default: begin
			end
		endcase
		r.count = COUNT_W'(held_values.size());
		return r;
	endfunction

	function automatic void add_row(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v,
			bit typed, res_t want);
		row_t row;
		row.c.op = op;
		row.c.value = v;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	function automatic void build_directed_rows();
		res_t none_empty;
		res_t none_ok;
		logic [OP_W-1:0] op;
		logic signed [DATA_W-1:0] v;
		none_empty = outcome('0, 1'b0, ST_EMPTY, 0);
		none_ok = outcome('0, 1'b0, ST_OK, 0);
		add_row(OP_POP_FRONT, '0, 1'b1, none_empty);
		add_row(OP_POP_BACK, '1, 1'b1, none_empty);
		add_row(OP_REM_MID, 32'h0000_0007, 1'b1, none_empty);
		add_row(OP_SPARE_LO, 32'h7FFF_FFFF, 1'b1, none_ok);
		add_row(OP_SPARE_HI, 32'h8000_0000, 1'b1, none_ok);
		add_row(OP_INS_MID, 32'h7FFF_FFFF, 1'b1, outcome('0, 1'b0, ST_OK, 1));
		add_row(OP_REM_MID, '0, 1'b1, outcome(32'h7FFF_FFFF, 1'b1, ST_OK, 0));
		for (int i = 0; i < CAPACITY; i++) begin
			case (i % 3)
				0: op = OP_PUSH_FRONT;
				1: op = OP_PUSH_BACK;
				default: op = OP_INS_MID;
			endcase
			case (i)
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				2: v = '0;
				3: v = '1;
				default: v = $urandom();
			endcase
			add_row(op, v, 1'b0, '0);
		end
		add_row(OP_PUSH_BACK, 32'h0000_0001, 1'b1, outcome('0, 1'b0, ST_FULL, CAPACITY));
		add_row(OP_REM_MID, '0, 1'b0, '0);
		add_row(OP_POP_FRONT, '0, 1'b0, '0);
		add_row(OP_POP_BACK, '0, 1'b0, '0);
	endfunction

	function automatic cmd_t random_cmd(bit filling);
		cmd_t c;
		int pick;
		int kind;
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 2);
		case ($urandom_range(0, 9))
			0: c.value = 32'h8000_0000;
			1: c.value = 32'h7FFF_FFFF;
			2: c.value = '0;
			3: c.value = '1;
			default: c.value = $urandom();
		endcase
		if (pick < 4) begin
			c.op = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
		end else if ((pick < 76) == filling) begin
			case (kind)
				0: c.op = OP_PUSH_FRONT;
				1: c.op = OP_PUSH_BACK;
				default: c.op = OP_INS_MID;
			endcase
		end else begin
			case (kind)
				0: c.op = OP_POP_FRONT;
				1: c.op = OP_POP_BACK;
				default: c.op = OP_REM_MID;
			endcase
		end
		return c;
	endfunction

	task automatic check_result(res_t got);
		res_t want;
		if (awaited_results.size() == 0) begin
			if (mismatches < REPORT_LIMIT)
				$display("unexpected result transfer: value=%0d valid=%0b status=%0d count=%0d",
					got.removed_value, got.removed_valid, got.status, got.count);
			mismatches++;
		end else begin
			want = awaited_results.pop_front();
			if (got.removed_value !== want.removed_value
					|| got.removed_valid !== want.removed_valid
					|| got.status !== want.status || got.count !== want.count) begin
				if (mismatches < REPORT_LIMIT) begin
					$write("mismatch: expected value=%0d valid=%0b status=%0d count=%0d,",
						want.removed_value, want.removed_valid, want.status, want.count);
					$display(" got value=%0d valid=%0b status=%0d count=%0d",
						got.removed_value, got.removed_valid, got.status, got.count);
				end
				mismatches++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) check_result(res);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((cmd_valid && cmd_stall === 1'b0) || (res_valid === 1'b1 && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin : receiver_stall
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeeze_done) begin
				res_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_stall = 1'b0;
				squeeze_done = 1'b1;
			end else if (!calm && arst_n && $urandom_range(0, 9) == 0) begin
				res_stall = 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				res_stall = 1'b0;
			end
		end
	end

	initial begin : stimulus
		row_t row;
		res_t guess;
		bit filling;
		int phase_left;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		filling = 1'b1;
		phase_left = 20;
		build_directed_rows();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int i = 0; i < ITEMS; i++) begin
			if (i < directed_rows.size()) begin
				row = directed_rows[i];
			end else begin
				if (phase_left == 0) begin
					filling = !filling;
					phase_left = $urandom_range(10, 50);
				end
				phase_left--;
				row.c = random_cmd(filling);
				row.typed = 1'b0;
				row.want = '0;
			end
			calm = (i >= ITEMS - CALM_ITEMS);
			if (i == ITEMS / 2) squeeze_req = 1'b1;
			if (!calm && !(squeeze_req && !squeeze_done) && $urandom_range(0, 7) == 0) begin
				cmd_valid = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			cmd = row.c;
			cmd_valid = 1'b1;
			do @(posedge clk); while (cmd_stall !== 1'b0);
			guess = apply_op(row.c);
			awaited_results.push_back(row.typed ? row.want : guess);
			@(negedge clk);
		end
		cmd_valid = 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/sbfbm_pkg.sv
rtl/sbfbm_cell.sv
rtl/sbfbm_ctrl.sv
rtl/sequence_buffer_front_back_middle.sv
tb/testbench.sv
